/* src/epmf_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and register indexes for the edge-preserving median filter.
// No dependencies.
package epmf_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int MAG_BITS       = SAMPLE_BITS - 1;
  localparam int MAX_WIDTH      = 1024;
  localparam int MAX_HALF       = 3;
  localparam int RING_DEPTH     = (2 * MAX_HALF + 2) * MAX_WIDTH;
  localparam int ADDR_BITS      = $clog2(RING_DEPTH);
  localparam int WIN_SIZE       = (2 * MAX_HALF + 1) * (2 * MAX_HALF + 1);
  localparam int WIN_CNT_BITS   = $clog2(WIN_SIZE + 1);
  localparam int MAG_STEP_BITS  = $clog2(MAG_BITS);
  localparam int POS_BITS       = 23;
  localparam int POS_STEP_BITS  = $clog2(POS_BITS);
  localparam int COL_BITS       = 10;
  localparam int ROW_BITS       = 13;
  localparam int HALF_BITS      = 2;
  localparam int WIDTH_BITS     = 11;
  localparam int HEIGHT_BITS    = 13;
  localparam int THR_BITS       = 20;
  localparam int CFG_DATA_BITS  = 20;
  localparam int CFG_INDEX_BITS = 3;
  localparam int TDATA_BITS     = 32;
  localparam int WIN_OFF_BITS   = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_KERNEL_HALF       = 3'd0,
    CFG_IMAGE_WIDTH       = 3'd1,
    CFG_IMAGE_HEIGHT      = 3'd2,
    CFG_EDGE_THRESHOLD    = 3'd3,
    CFG_THRESHOLD_ENABLE  = 3'd4,
    CFG_SPECKLE_THRESHOLD = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic                          nan;
    logic signed [SAMPLE_BITS-1:0] value;
  } pixel_t;

  typedef struct packed {
    logic clr;
    logic push;
    logic start;
  } sel_ctrl_t;

endpackage

/* src/epmf_line_store.sv */
`timescale 1ns / 1ps
// Ring of recent pixels: one write port, one registered read port.
// Depends on epmf_pkg.
module epmf_line_store (
  input  logic                            clk,
  input  logic                            we,
  input  logic [epmf_pkg::ADDR_BITS-1:0]  waddr,
  input  epmf_pkg::pixel_t                wdata,
  input  logic [epmf_pkg::ADDR_BITS-1:0]  raddr,
  output epmf_pkg::pixel_t                rdata
);

  epmf_pkg::pixel_t mem [epmf_pkg::RING_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/epmf_pos_div.sv */
`timescale 1ns / 1ps
// Bit-serial restoring divider: splits the output raster index into row and column.
// Depends on epmf_pkg.
module epmf_pos_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [epmf_pkg::POS_BITS-1:0]   dividend,
  input  logic [epmf_pkg::WIDTH_BITS-1:0] divisor,
  output logic                            done,
  output logic [epmf_pkg::POS_BITS-1:0]   quotient,
  output logic [epmf_pkg::WIDTH_BITS-1:0] remainder
);

  logic                                 busy;
  logic [epmf_pkg::POS_STEP_BITS-1:0]   step;
  logic [epmf_pkg::POS_BITS-1:0]        dvd;
  logic [epmf_pkg::WIDTH_BITS-1:0]      rem;
  logic [epmf_pkg::WIDTH_BITS:0]        trial;
  logic [epmf_pkg::WIDTH_BITS:0]        diff;
  logic                                 fits;
  logic                                 last_step;

  assign trial     = {rem, dvd[epmf_pkg::POS_BITS-1]};
  assign diff      = trial - {1'b0, divisor};
  assign fits      = trial >= {1'b0, divisor};
  assign quotient  = dvd;
  assign remainder = rem;
  assign last_step = (step == epmf_pkg::POS_STEP_BITS'(epmf_pkg::POS_BITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= !start && busy && last_step;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        dvd  <= dividend;
        rem  <= '0;
      end else if (busy) begin
        rem  <= fits ? diff[epmf_pkg::WIDTH_BITS-1:0] : trial[epmf_pkg::WIDTH_BITS-1:0];
        dvd  <= {dvd[epmf_pkg::POS_BITS-2:0], fits};
        step <= step + 1'b1;
        if (last_step) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

/* src/epmf_median_sel.sv */
`timescale 1ns / 1ps
// Window shift registers and bit-serial rank selection of the upper median.
// Depends on epmf_pkg.
module epmf_median_sel (
  input  logic                          clk,
  input  logic                          rst,
  input  epmf_pkg::sel_ctrl_t           ctrl,
  input  logic [epmf_pkg::MAG_BITS-1:0] push_value,
  output logic                          done,
  output logic [epmf_pkg::MAG_BITS-1:0] median
);

  logic [epmf_pkg::MAG_BITS-1:0]      win [epmf_pkg::WIN_SIZE];
  logic [epmf_pkg::WIN_SIZE-1:0]      act;
  logic [epmf_pkg::WIN_SIZE-1:0]      msb;
  logic [epmf_pkg::WIN_SIZE-1:0]      zeros;
  logic [epmf_pkg::WIN_CNT_BITS-1:0]  cnt;
  logic [epmf_pkg::WIN_CNT_BITS-1:0]  rank;
  logic [epmf_pkg::WIN_CNT_BITS-1:0]  zc;
  logic [epmf_pkg::MAG_STEP_BITS-1:0] step;
  logic                               busy;
  logic                               last_step;

  always_comb begin
    for (int i = 0; i < epmf_pkg::WIN_SIZE; i++) begin
      msb[i] = win[i][epmf_pkg::MAG_BITS-1];
    end
  end

  assign zeros     = act & ~msb;
  assign zc        = epmf_pkg::WIN_CNT_BITS'($countones(zeros));
  assign last_step = (step == epmf_pkg::MAG_STEP_BITS'(epmf_pkg::MAG_BITS - 1));

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      win[0] <= push_value;
      for (int i = 1; i < epmf_pkg::WIN_SIZE; i++) begin
        win[i] <= win[i-1];
      end
    end else if (busy) begin
      for (int i = 0; i < epmf_pkg::WIN_SIZE; i++) begin
        win[i] <= {win[i][epmf_pkg::MAG_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act  <= '0;
      cnt  <= '0;
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= !ctrl.clr && !ctrl.push && !ctrl.start && busy && last_step;
      if (ctrl.clr) begin
        act <= '0;
        cnt <= '0;
      end else if (ctrl.push) begin
        act <= {act[epmf_pkg::WIN_SIZE-2:0], 1'b1};
        cnt <= cnt + 1'b1;
      end else if (ctrl.start) begin
        rank <= cnt >> 1;
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (rank < zc) begin
          act    <= zeros;
          median <= {median[epmf_pkg::MAG_BITS-2:0], 1'b0};
        end else begin
          rank   <= rank - zc;
          act    <= act & msb;
          median <= {median[epmf_pkg::MAG_BITS-2:0], 1'b1};
        end
        step <= step + 1'b1;
        if (last_step) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

/* src/edge_preserving_median_filter_unit.sv */
`timescale 1ns / 1ps
// Edge-preserving median filter over a raster depth image; top level with control sequencer.
// Depends on epmf_pkg, epmf_line_store, epmf_pos_div, epmf_median_sel.
//
// A pixel request or a drain request that yields no output leaves the sequencer idle, so the
// input stays open. A request that yields an output keeps the input closed until its result
// is registered: the output index is split into row and column by the bit-serial divider (23
// divide steps); on a filtered pixel the window is then read one pixel per cycle through the
// single line store read port and the median is found by bit-serial selection (23 bit steps).
// Border and invalid pixels skip both. The result waits in an output register, so the next
// request is taken while it is still held. The line store has no clearing pass.
module edge_preserving_median_filter_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // sample[23:0], sample_is_nan[24], zero fill
  input  logic [epmf_pkg::TDATA_BITS-1:0]       s_tdata,
  // command[0]
  input  logic [0:0]                            s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // filtered_sample[23:0], filtered_is_nan[24], speckle[25], zero fill
  output logic [epmf_pkg::TDATA_BITS-1:0]       m_tdata,
  output logic                                  m_tlast,
  input  logic                                  cfg_we,
  input  logic [epmf_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [epmf_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_GATHER, S_GLAST, S_START, S_SELECT, S_FINISH
  } state_t;

  state_t state;

  logic [epmf_pkg::HALF_BITS-1:0]   kernel_half;
  logic [epmf_pkg::WIDTH_BITS-1:0]  image_width;
  logic [epmf_pkg::HEIGHT_BITS-1:0] image_height;
  logic [epmf_pkg::THR_BITS-1:0]    edge_threshold;
  logic                             threshold_enable;
  logic [epmf_pkg::THR_BITS-1:0]    speckle_threshold;

  logic [epmf_pkg::COL_BITS-1:0]    in_column;
  logic [epmf_pkg::ROW_BITS-1:0]    in_row;
  logic [epmf_pkg::POS_BITS-1:0]    out_position;
  logic [epmf_pkg::ADDR_BITS-1:0]   wr_ptr;
  logic [epmf_pkg::ADDR_BITS-1:0]   pending;
  logic [epmf_pkg::ADDR_BITS-1:0]   op;
  logic [epmf_pkg::ADDR_BITS-1:0]   rb;
  logic [epmf_pkg::WIN_OFF_BITS-1:0] dx;
  logic [epmf_pkg::WIN_OFF_BITS-1:0] dy;
  logic                             gv;
  logic                             fpath;
  epmf_pkg::pixel_t                 cen;
  logic [epmf_pkg::SAMPLE_BITS-1:0] out_sample;
  logic                             out_nan;
  logic                             out_speckle;

  logic [epmf_pkg::HALF_BITS-1:0]   eh;
  logic [epmf_pkg::WIDTH_BITS-1:0]  ew;
  logic [epmf_pkg::HEIGHT_BITS-1:0] ehg;
  logic [epmf_pkg::ADDR_BITS-1:0]   lag;
  logic [epmf_pkg::POS_BITS:0]      frame_size;
  logic [epmf_pkg::WIN_OFF_BITS-1:0] span;

  logic                             acc;
  logic                             cmd;
  epmf_pkg::pixel_t                 in_pix;
  logic [epmf_pkg::COL_BITS:0]      col_inc;
  logic [epmf_pkg::ROW_BITS:0]      row_inc;
  logic [epmf_pkg::ADDR_BITS-1:0]   pend_inc;
  logic                             emit;

  logic [epmf_pkg::ADDR_BITS-1:0]   raddr;
  epmf_pkg::pixel_t                 rd_data;

  logic                             div_done;
  logic [epmf_pkg::POS_BITS-1:0]    quo;
  logic [epmf_pkg::WIDTH_BITS-1:0]  rem;
  logic                             border;
  logic                             cen_ok;

  logic                             p_ok;
  logic signed [epmf_pkg::SAMPLE_BITS:0] pdiff;
  logic [epmf_pkg::SAMPLE_BITS:0]   pabs;
  logic                             keep;

  epmf_pkg::sel_ctrl_t              sel_ctrl;
  logic                             sel_done;
  logic [epmf_pkg::MAG_BITS-1:0]    median;

  logic [epmf_pkg::SAMPLE_BITS-1:0] fv;
  logic signed [epmf_pkg::SAMPLE_BITS:0] sdiff;
  logic [epmf_pkg::SAMPLE_BITS:0]   sabs;
  logic                             spk;
  logic                             out_free;
  logic                             last;

  // effective configuration
  always_comb begin
    eh = (kernel_half > epmf_pkg::HALF_BITS'(epmf_pkg::MAX_HALF))
         ? epmf_pkg::HALF_BITS'(epmf_pkg::MAX_HALF) : kernel_half;
    if (image_width == '0) begin
      ew = epmf_pkg::WIDTH_BITS'(1);
    end else if (image_width > epmf_pkg::WIDTH_BITS'(epmf_pkg::MAX_WIDTH)) begin
      ew = epmf_pkg::WIDTH_BITS'(epmf_pkg::MAX_WIDTH);
    end else begin
      ew = image_width;
    end
    ehg = (image_height == '0) ? epmf_pkg::HEIGHT_BITS'(1) : image_height;
  end

  assign lag = epmf_pkg::ADDR_BITS'(eh) * epmf_pkg::ADDR_BITS'(ew)
             + epmf_pkg::ADDR_BITS'(eh);
  assign frame_size = (epmf_pkg::POS_BITS + 1)'(ew) * (epmf_pkg::POS_BITS + 1)'(ehg);
  assign span = {1'b0, eh} << 1;

  // input side
  assign s_tready = (state == S_IDLE);
  assign acc      = s_tvalid && s_tready;
  assign cmd      = s_tuser[0];
  assign in_pix   = s_tdata[epmf_pkg::SAMPLE_BITS:0];
  assign col_inc  = {1'b0, in_column} + 1'b1;
  assign row_inc  = {1'b0, in_row} + 1'b1;
  assign pend_inc = pending + 1'b1;
  assign emit     = cmd ? (pending != '0 && in_column == '0 && in_row == '0)
                        : (pend_inc > lag);

  assign raddr = (state == S_GATHER) ? rb + epmf_pkg::ADDR_BITS'(dx) : op;

  epmf_line_store u_store (
    .clk   (clk),
    .we    (acc && !cmd),
    .waddr (wr_ptr),
    .wdata (in_pix),
    .raddr (raddr),
    .rdata (rd_data)
  );

  epmf_pos_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (acc && emit),
    .dividend  (out_position),
    .divisor   (ew),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  assign border = (quo < epmf_pkg::POS_BITS'(eh))
               || ((epmf_pkg::POS_BITS + 1)'(quo) + (epmf_pkg::POS_BITS + 1)'(eh)
                   >= (epmf_pkg::POS_BITS + 1)'(ehg))
               || (rem < epmf_pkg::WIDTH_BITS'(eh))
               || ({1'b0, rem} + (epmf_pkg::WIDTH_BITS + 1)'(eh) >= {1'b0, ew});
  assign cen_ok = !rd_data.nan && !rd_data.value[epmf_pkg::SAMPLE_BITS-1]
               && rd_data.value != '0;

  // window pixel test
  assign p_ok  = !rd_data.nan && !rd_data.value[epmf_pkg::SAMPLE_BITS-1]
              && rd_data.value != '0;
  assign pdiff = {rd_data.value[epmf_pkg::SAMPLE_BITS-1], rd_data.value}
               - {cen.value[epmf_pkg::SAMPLE_BITS-1], cen.value};
  assign pabs  = pdiff[epmf_pkg::SAMPLE_BITS] ? -pdiff : pdiff;
  assign keep  = p_ok && (!threshold_enable
               || pabs <= (epmf_pkg::SAMPLE_BITS + 1)'(edge_threshold));

  always_comb begin
    sel_ctrl.clr   = (state == S_DIV) && div_done;
    sel_ctrl.push  = gv && keep;
    sel_ctrl.start = (state == S_START);
  end

  epmf_median_sel u_sel (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (sel_ctrl),
    .push_value (rd_data.value[epmf_pkg::MAG_BITS-1:0]),
    .done       (sel_done),
    .median     (median)
  );

  // result
  assign fv    = {1'b0, median};
  assign sdiff = {cen.value[epmf_pkg::SAMPLE_BITS-1], cen.value} - {1'b0, fv};
  assign sabs  = sdiff[epmf_pkg::SAMPLE_BITS] ? -sdiff : sdiff;
  assign spk   = sabs > (epmf_pkg::SAMPLE_BITS + 1)'(speckle_threshold);
  assign out_free = !m_tvalid || m_tready;
  assign last  = ({1'b0, out_position} + 1'b1) >= frame_size;

  assign m_tdata = {{(epmf_pkg::TDATA_BITS - epmf_pkg::SAMPLE_BITS - 2){1'b0}},
                    out_speckle, out_nan, out_sample};

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_half       <= epmf_pkg::HALF_BITS'(2);
      image_width       <= epmf_pkg::WIDTH_BITS'(640);
      image_height      <= epmf_pkg::HEIGHT_BITS'(480);
      edge_threshold    <= epmf_pkg::THR_BITS'(160);
      threshold_enable  <= 1'b1;
      speckle_threshold <= epmf_pkg::THR_BITS'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        epmf_pkg::CFG_KERNEL_HALF:
          kernel_half <= cfg_data[epmf_pkg::HALF_BITS-1:0];
        epmf_pkg::CFG_IMAGE_WIDTH:
          image_width <= cfg_data[epmf_pkg::WIDTH_BITS-1:0];
        epmf_pkg::CFG_IMAGE_HEIGHT:
          image_height <= cfg_data[epmf_pkg::HEIGHT_BITS-1:0];
        epmf_pkg::CFG_EDGE_THRESHOLD:
          edge_threshold <= cfg_data[epmf_pkg::THR_BITS-1:0];
        epmf_pkg::CFG_THRESHOLD_ENABLE:
          threshold_enable <= cfg_data[0];
        epmf_pkg::CFG_SPECKLE_THRESHOLD:
          speckle_threshold <= cfg_data[epmf_pkg::THR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      in_column    <= '0;
      in_row       <= '0;
      out_position <= '0;
      wr_ptr       <= '0;
      pending      <= '0;
      gv           <= 1'b0;
      m_tvalid     <= 1'b0;
      m_tlast      <= 1'b0;
    end else begin
      gv <= (state == S_GATHER);
      if (state == S_FINISH && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            op <= wr_ptr - pending;
            if (!cmd) begin
              wr_ptr  <= wr_ptr + 1'b1;
              pending <= pend_inc;
              if (col_inc >= (epmf_pkg::COL_BITS + 1)'(ew)) begin
                in_column <= '0;
                in_row    <= (row_inc >= (epmf_pkg::ROW_BITS + 1)'(ehg))
                             ? '0 : row_inc[epmf_pkg::ROW_BITS-1:0];
              end else begin
                in_column <= col_inc[epmf_pkg::COL_BITS-1:0];
              end
            end
            if (emit) begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            cen   <= rd_data;
            fpath <= !border && cen_ok;
            rb    <= op - lag;
            dx    <= '0;
            dy    <= '0;
            state <= (!border && cen_ok) ? S_GATHER : S_FINISH;
          end
        end
        S_GATHER: begin
          if (dx == span) begin
            dx <= '0;
            rb <= rb + epmf_pkg::ADDR_BITS'(ew);
            if (dy == span) begin
              state <= S_GLAST;
            end else begin
              dy <= dy + 1'b1;
            end
          end else begin
            dx <= dx + 1'b1;
          end
        end
        S_GLAST: begin
          state <= S_START;
        end
        S_START: begin
          state <= S_SELECT;
        end
        S_SELECT: begin
          if (sel_done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_sample  <= fpath ? fv : cen.value;
            out_nan     <= fpath ? 1'b0 : cen.nan;
            out_speckle <= fpath && spk;
            m_tlast     <= last;
            out_position <= last ? '0 : out_position + 1'b1;
            pending     <= pending - 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sim/edge_preserving_median_filter_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for edge_preserving_median_filter_unit: raster frames of Q20.4 pixels
// and drain requests go in, filtered pixels are compared with a built-in filter predictor.
// Depends on epmf_pkg and the filter RTL only.
module edge_preserving_median_filter_unit_tb;

  localparam int QUIET_LIMIT = 20000;
  localparam int SETTLE      = 150;

  typedef struct {
    logic signed [epmf_pkg::SAMPLE_BITS-1:0] value;
    logic                                    nan;
    logic                                    speckle;
    logic                                    last;
  } filtered_px_t;

  typedef struct {
    bit                                      drain;
    logic signed [epmf_pkg::SAMPLE_BITS-1:0] value;
    bit                                      nan;
    bit                                      typed;
  } stim_row_t;

  logic                                  clk = 0;
  logic                                  rst = 1;
  logic                                  s_tvalid = 0;
  logic                                  s_tready;
  logic [epmf_pkg::TDATA_BITS-1:0]       s_tdata = '0;
  logic [0:0]                            s_tuser = '0;
  logic                                  m_tvalid;
  logic                                  m_tready = 0;
  logic [epmf_pkg::TDATA_BITS-1:0]       m_tdata;
  logic                                  m_tlast;
  logic                                  cfg_we = 0;
  logic [epmf_pkg::CFG_INDEX_BITS-1:0]   cfg_index = '0;
  logic [epmf_pkg::CFG_DATA_BITS-1:0]    cfg_data = '0;

  edge_preserving_median_filter_unit u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // filter state mirror
  epmf_pkg::pixel_t ring_px [epmf_pkg::RING_DEPTH];
  int unsigned wr_ptr, pend_cnt, col_in, row_in, out_pos;
  logic [1:0]  k_half = 2;
  logic [10:0] img_w = 640;
  logic [12:0] img_h = 480;
  logic [19:0] edge_thr = 160;
  logic        thr_en = 1;
  logic [19:0] speckle_thr = 16;

  filtered_px_t filtered_q[$];
  int errors = 0, pixels_sent = 0, drains_sent = 0, results_seen = 0;
  int send_idle_pct = 0, recv_stall_pct = 0, hold_left = 0, quiet = 0;
  bit hold_req = 0;

  function automatic int unsigned eff_w();
    return img_w < 1 ? 1 : (img_w > epmf_pkg::MAX_WIDTH ? epmf_pkg::MAX_WIDTH : img_w);
  endfunction

  function automatic int unsigned eff_hgt();
    return img_h < 1 ? 1 : img_h;
  endfunction

  function automatic longint absdiff(longint a, longint b);
    return a > b ? a - b : b - a;
  endfunction

  function automatic filtered_px_t filter_oldest();
    int unsigned h, w, hg, op, orow, ocol, idx;
    epmf_pkg::pixel_t c, p;
    longint win[epmf_pkg::WIN_SIZE];
    longint key, fv;
    int n, i, j;
    bit border;
    filtered_px_t r;
    h = k_half; w = eff_w(); hg = eff_hgt();
    op = (wr_ptr + epmf_pkg::RING_DEPTH - pend_cnt) % epmf_pkg::RING_DEPTH;
    orow = out_pos / w; ocol = out_pos % w;
    c = ring_px[op];
    fv = c.value;
    r.nan = c.nan;
    r.speckle = 0;
    border = orow < h || orow + h >= hg || ocol < h || ocol + h >= w;
    if (!border && !c.nan && c.value > 0) begin
      n = 0;
      for (int dy = -int'(h); dy <= int'(h); dy++) begin
        for (int dx = -int'(h); dx <= int'(h); dx++) begin
          idx = (int'(op) + epmf_pkg::RING_DEPTH + dy * int'(w) + dx) % epmf_pkg::RING_DEPTH;
          p = ring_px[idx];
          if (p.nan || p.value <= 0) continue;
          if (thr_en && absdiff(p.value, c.value) > edge_thr) continue;
          win[n] = p.value;
          n++;
        end
      end
      for (i = 1; i < n; i++) begin
        key = win[i];
        for (j = i - 1; j >= 0 && win[j] > key; j--) win[j + 1] = win[j];
        win[j + 1] = key;
      end
      fv = win[n / 2];
      r.nan = 0;
      r.speckle = absdiff(c.value, fv) > speckle_thr;
    end
    r.value = fv[epmf_pkg::SAMPLE_BITS-1:0];
    r.last = out_pos + 1 >= w * hg;
    out_pos = r.last ? 0 : out_pos + 1;
    pend_cnt--;
    return r;
  endfunction

  task automatic predict_filter(input bit drain,
                                input logic signed [epmf_pkg::SAMPLE_BITS-1:0] value,
                                input bit nan, output bit emitted, output filtered_px_t r);
    int unsigned h, w, hg;
    h = k_half; w = eff_w(); hg = eff_hgt();
    emitted = 0;
    if (!drain) begin
      ring_px[wr_ptr] = '{nan: nan, value: value};
      wr_ptr = (wr_ptr + 1) % epmf_pkg::RING_DEPTH;
      if (col_in + 1 >= w) begin
        col_in = 0;
        row_in = (row_in + 1 >= hg) ? 0 : row_in + 1;
      end else begin
        col_in++;
      end
      pend_cnt++;
      if (pend_cnt > h * w + h) begin
        r = filter_oldest();
        emitted = 1;
      end
    end else if (pend_cnt > 0 && col_in == 0 && row_in == 0) begin
      r = filter_oldest();
      emitted = 1;
    end
  endtask

  task automatic write_reg(input epmf_pkg::cfg_index_t idx, input int unsigned val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val[epmf_pkg::CFG_DATA_BITS-1:0];
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      epmf_pkg::CFG_KERNEL_HALF:       k_half = val[1:0];
      epmf_pkg::CFG_IMAGE_WIDTH:       img_w = val[10:0];
      epmf_pkg::CFG_IMAGE_HEIGHT:      img_h = val[12:0];
      epmf_pkg::CFG_EDGE_THRESHOLD:    edge_thr = val[19:0];
      epmf_pkg::CFG_THRESHOLD_ENABLE:  thr_en = val[0];
      epmf_pkg::CFG_SPECKLE_THRESHOLD: speckle_thr = val[19:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_request(input stim_row_t row);
    bit emitted;
    filtered_px_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= row.drain;
    s_tdata <= {{(epmf_pkg::TDATA_BITS-epmf_pkg::SAMPLE_BITS-1){1'b0}}, row.nan, row.value};
    do @(posedge clk); while (!s_tready);
    predict_filter(row.drain, row.value, row.nan, emitted, r);
    if (row.drain) drains_sent++;
    else pixels_sent++;
    if (emitted) begin
      // 1x1 window with a one-pixel frame: every pixel comes straight back as the frame end
      if (row.typed) r = '{value: row.value, nan: row.nan, speckle: 0, last: 1};
      filtered_q.insert(filtered_q.size(), r);
    end
  endtask

  task automatic settle();
    s_tvalid <= 0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic stim_row_t random_pixel(int base);
    stim_row_t row;
    int pick;
    row.drain = 0;
    row.typed = 0;
    row.nan = $urandom_range(11) == 0;
    pick = $urandom_range(59);
    if (pick < 3) row.value = epmf_pkg::SAMPLE_BITS'($urandom);
    else if (pick < 6) row.value = -$signed(24'($urandom_range(5000)));
    else if (pick < 8) row.value = 0;
    else if (pick < 11) row.value = epmf_pkg::SAMPLE_BITS'(base + $urandom_range(20000));
    else row.value = epmf_pkg::SAMPLE_BITS'(base + $urandom_range(120) - 60);
    return row;
  endfunction

  task automatic run_frames(int frames, bit pressure);
    stim_row_t row;
    int base, n;
    n = eff_w() * eff_hgt();
    for (int f = 0; f < frames; f++) begin
      base = $urandom_range(2000, 100);
      for (int i = 0; i < n; i++) begin
        if (pressure && f == 0 && i == n / 2) hold_req = 1;
        if ($urandom_range(24) == 0) begin
          row = '{drain: 1, value: epmf_pkg::SAMPLE_BITS'($urandom),
                  nan: 1'($urandom_range(1)), typed: 0};
          send_request(row);
        end
        send_request(random_pixel(base));
      end
    end
    while (pend_cnt > 0) begin
      row = '{drain: 1, value: epmf_pkg::SAMPLE_BITS'($urandom),
              nan: 1'($urandom_range(1)), typed: 0};
      send_request(row);
    end
    settle();
  endtask

  always @(posedge clk) begin
    filtered_px_t exp_px, got;
    if (rst) begin
      m_tready <= 0;
    end else begin
      if (hold_req) begin
        hold_req = 0;
        m_tready <= 0;
        hold_left <= 2500;
      end else if (hold_left > 0) begin
        m_tready <= 0;
        hold_left <= hold_left - 1;
      end else begin
        m_tready <= $urandom_range(99) >= recv_stall_pct;
      end
      if (m_tvalid && m_tready) begin
        got = '{value: m_tdata[epmf_pkg::SAMPLE_BITS-1:0], nan: m_tdata[epmf_pkg::SAMPLE_BITS],
                speckle: m_tdata[epmf_pkg::SAMPLE_BITS+1], last: m_tlast};
        results_seen++;
        if (filtered_q.size() == 0) begin
          $display("%0t: unexpected result value=%0d nan=%0b speckle=%0b last=%0b",
                   $time, got.value, got.nan, got.speckle, got.last);
          errors++;
        end else begin
          exp_px = filtered_q.pop_front();
          if (got.value !== exp_px.value || got.nan !== exp_px.nan ||
              got.speckle !== exp_px.speckle || got.last !== exp_px.last) begin
            $display("%0t: mismatch expected value=%0d nan=%0b speckle=%0b last=%0b",
                     $time, exp_px.value, exp_px.nan, exp_px.speckle, exp_px.last);
            $display("%0t:          actual   value=%0d nan=%0b speckle=%0b last=%0b",
                     $time, got.value, got.nan, got.speckle, got.last);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    stim_row_t directed[$];
    int phase;
    for (int i = 0; i < epmf_pkg::RING_DEPTH; i++) ring_px[i] = '0;
    wr_ptr = 0; pend_cnt = 0; col_in = 0; row_in = 0; out_pos = 0;
    directed = '{
      '{0, 24'sd1,        0, 1}, '{0, 24'sd8388607,  0, 1}, '{0, -24'sd8388608, 0, 1},
      '{0, 24'sd0,        0, 1}, '{0, -24'sd1,       0, 1}, '{1, 24'sd77,       0, 1},
      '{0, 24'sd1234,     1, 1}, '{0, 24'sd8388607,  1, 1}, '{0, -24'sd8388608, 1, 1},
      '{1, 24'sd0,        1, 1}, '{0, 24'sh555555,   0, 1}, '{0, 24'shAAAAAA,   1, 1},
      '{0, 24'sd160,      0, 1}, '{0, 24'sd16,       0, 1}, '{1, -24'sd1,       0, 1},
      '{0, 24'sd3,        0, 1}
    };
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // one-pixel frame with a 1x1 window
    write_reg(epmf_pkg::CFG_KERNEL_HALF, 0);
    write_reg(epmf_pkg::CFG_IMAGE_WIDTH, 0);
    write_reg(epmf_pkg::CFG_IMAGE_HEIGHT, 0);
    foreach (directed[i]) send_request(directed[i]);
    settle();

    phase = 0;
    while (pixels_sent + drains_sent < 1200 || phase < 5) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      write_reg(epmf_pkg::CFG_KERNEL_HALF, phase < 3 ? phase + 1 : $urandom_range(3));
      write_reg(epmf_pkg::CFG_IMAGE_WIDTH, phase == 0 ? 8 : $urandom_range(14, 8));
      write_reg(epmf_pkg::CFG_IMAGE_HEIGHT, phase == 1 ? 8 : $urandom_range(12, 8));
      case ($urandom_range(3))
        0: write_reg(epmf_pkg::CFG_EDGE_THRESHOLD, 0);
        1: write_reg(epmf_pkg::CFG_EDGE_THRESHOLD, 20'hFFFFF);
        default: write_reg(epmf_pkg::CFG_EDGE_THRESHOLD, $urandom_range(400));
      endcase
      write_reg(epmf_pkg::CFG_THRESHOLD_ENABLE, $urandom_range(3) != 0);
      case ($urandom_range(3))
        0: write_reg(epmf_pkg::CFG_SPECKLE_THRESHOLD, 0);
        1: write_reg(epmf_pkg::CFG_SPECKLE_THRESHOLD, 20'hFFFFF);
        default: write_reg(epmf_pkg::CFG_SPECKLE_THRESHOLD, $urandom_range(64));
      endcase
      run_frames($urandom_range(2, 1), phase == 4);
      phase++;
    end

    $display("Covered %0d pixels and %0d drain requests over %0d settings, %0d results checked",
             pixels_sent, drains_sent, phase + 1, results_seen);
    $display("Windows 1x1 to 7x7, edge and speckle limits at both ends, with stalls on each side");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* edge_preserving_median_filter_unit.f */
src/epmf_pkg.sv
src/epmf_line_store.sv
src/epmf_pos_div.sv
src/epmf_median_sel.sv
src/edge_preserving_median_filter_unit.sv
sim/edge_preserving_median_filter_unit_tb.sv
